// File: hdl/mprt_pkg.sv
// ----------------------------------------------------------------------------
// mprt_pkg: shared types and constants of the point renumbering table
// Map geometry, action codes, controller states and the command/status
// structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package mprt_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int NUM_W      = 12;  // new index width
    localparam int CNT_W      = 13;  // counters and num_points
    localparam int ENTRY_W    = 14;  // assigned, boundary, number

    // map entry bit positions
    localparam int BIT_ASSIGNED = 13;
    localparam int BIT_BOUNDARY = 12;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_BOUNDARY = 2'd1,
        ACT_INTERNAL = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch item, issue map read
        logic exec;      // apply item, write map, load result
        logic clr_step;  // clear one map entry
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_start;  // latched item is a start
        logic clr_last;  // clear pointer at last entry
    } t_dp_status;

endpackage

// File: hdl/mprt_ctrl.sv
// ----------------------------------------------------------------------------
// mprt_ctrl: controller of the point renumbering table
// Sequences accept, execute and the map clear sweep.
// ----------------------------------------------------------------------------
module mprt_ctrl import mprt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_status.op_start ? ST_CLEAR : ST_IDLE;
            end
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state register: reset starts a clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_busy           = (r_state != ST_IDLE);
    assign o_cmd.capture    = (r_state == ST_IDLE) && i_start;
    assign o_cmd.exec       = (r_state == ST_EXEC);
    assign o_cmd.clr_step   = (r_state == ST_CLEAR);

endmodule

// File: hdl/mprt_datapath.sv
// ----------------------------------------------------------------------------
// mprt_datapath: map memory, counters and result registers
// One map read per item, then a conditional write; clear sweep writes
// one entry per cycle.
// ----------------------------------------------------------------------------
module mprt_datapath import mprt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic [1:0]        i_action,
    input  logic [11:0]       i_point_index,
    input  logic              i_num_points_we,
    input  logic [12:0]       i_num_points,
    output logic              o_done,
    output logic [11:0]       o_mapped_index,
    output logic              o_mapped_valid,
    output logic [12:0]       o_internal_point_count,
    output logic [12:0]       o_boundary_point_count,
    output logic              o_is_ordered,
    output logic              o_index_error
);

    logic [ENTRY_W-1:0] r_mem [MAX_POINTS];
    logic [ENTRY_W-1:0] r_rdata;

    t_action            r_act;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  r_clr_ptr;
    logic [CNT_W-1:0]   r_num_points;
    logic [CNT_W-1:0]   r_bcnt, n_bcnt;
    logic [CNT_W-1:0]   r_icnt, n_icnt;
    logic               r_ord, n_ord;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               ex_wr;
    logic [ENTRY_W-1:0] ex_wdata;

    logic               err;
    logic               valid;
    logic [NUM_W-1:0]   mapped;
    logic [CNT_W-1:0]   icnt_cur;
    logic [CNT_W-1:0]   icnt_after;

    // saturating internal count
    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= '0;
        end else if (i_num_points_we) begin
            r_num_points <= i_num_points;
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= t_action'(i_action);
            r_idx <= i_point_index[ADDR_W-1:0];
        end
    end

    // clear pointer wraps back to zero at the end of each sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
        end
    end

    assign o_status.clr_last = (r_clr_ptr == {ADDR_W{1'b1}});
    assign o_status.op_start = (r_act == ACT_START);

    // execute stage
    always_comb begin
        icnt_cur = sat_sub(r_num_points, r_bcnt);
        err      = (r_act != ACT_START) &&
                   ({{(CNT_W-ADDR_W){1'b0}}, r_idx} >= r_num_points);
        n_bcnt   = r_bcnt;
        n_icnt   = r_icnt;
        n_ord    = r_ord;
        ex_wr    = 1'b0;
        ex_wdata = '0;
        valid    = 1'b0;
        mapped   = '0;
        case (r_act)
            ACT_START: begin
                n_bcnt = '0;
                n_icnt = '0;
                n_ord  = 1'b1;
            end
            ACT_BOUNDARY: begin
                if (!err && !r_rdata[BIT_ASSIGNED]) begin
                    ex_wr    = 1'b1;
                    ex_wdata = {1'b1, 1'b1, r_bcnt[NUM_W-1:0]};
                    n_bcnt   = r_bcnt + 1'b1;
                end
            end
            ACT_INTERNAL: begin
                if (!err && !r_rdata[BIT_ASSIGNED]) begin
                    if ({{(CNT_W-ADDR_W){1'b0}}, r_idx} >= icnt_cur) n_ord = 1'b0;
                    ex_wr    = 1'b1;
                    ex_wdata = {1'b1, 1'b0, r_icnt[NUM_W-1:0]};
                    n_icnt   = r_icnt + 1'b1;
                end
            end
            ACT_READ: begin
                if (!err && r_rdata[BIT_ASSIGNED]) begin
                    valid  = 1'b1;
                    mapped = r_rdata[BIT_BOUNDARY]
                           ? r_rdata[NUM_W-1:0] + icnt_cur[NUM_W-1:0]
                           : r_rdata[NUM_W-1:0];
                end
            end
            default: ;
        endcase
        icnt_after = sat_sub(r_num_points, n_bcnt);
    end

    // counters and flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
            r_icnt <= '0;
            r_ord  <= 1'b1;
        end else if (i_cmd.exec) begin
            r_bcnt <= n_bcnt;
            r_icnt <= n_icnt;
            r_ord  <= n_ord;
        end
    end

    // map memory port select
    assign wr_en   = i_cmd.clr_step || (i_cmd.exec && ex_wr);
    assign wr_addr = i_cmd.clr_step ? r_clr_ptr : r_idx;
    assign wr_data = i_cmd.clr_step ? '0 : ex_wdata;

    // map memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[i_point_index[ADDR_W-1:0]];
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.exec;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_mapped_index         <= mapped;
            o_mapped_valid         <= valid;
            o_internal_point_count <= icnt_after;
            o_boundary_point_count <= n_bcnt;
            o_is_ordered           <= n_ord;
            o_index_error          <= err;
        end
    end

endmodule

// File: hdl/mesh_point_renumber_table_core.sv
// ----------------------------------------------------------------------------
// mesh_point_renumber_table_core: mesh point renumbering table
// The accepting edge latches the item and the map read; the execute
// state writes the map back and registers the result strobe. A new item
// is taken only in idle, after the execute state of the last one. Reset
// and every start item run a clear sweep of the map, with busy high.
// The receiver cannot stall; results show for one cycle.
// ----------------------------------------------------------------------------
module mesh_point_renumber_table_core import mprt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_point_index,
    input  logic        i_num_points_we,
    input  logic [12:0] i_num_points,
    output logic        o_done,
    output logic [11:0] o_mapped_index,
    output logic        o_mapped_valid,
    output logic [12:0] o_internal_point_count,
    output logic [12:0] o_boundary_point_count,
    output logic        o_is_ordered,
    output logic        o_index_error
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    mprt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mprt_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_action               (i_action),
        .i_point_index          (i_point_index),
        .i_num_points_we        (i_num_points_we),
        .i_num_points           (i_num_points),
        .o_done                 (o_done),
        .o_mapped_index         (o_mapped_index),
        .o_mapped_valid         (o_mapped_valid),
        .o_internal_point_count (o_internal_point_count),
        .o_boundary_point_count (o_boundary_point_count),
        .o_is_ordered           (o_is_ordered),
        .o_index_error          (o_index_error)
    );

endmodule

// File: hdl/mprt_checker.sv
// ----------------------------------------------------------------------------
// mprt_checker: port-level checks of the point renumbering table
// Timing of transfers and consistency of result fields.
// ----------------------------------------------------------------------------
module mprt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [11:0] o_mapped_index,
    input logic        o_mapped_valid,
    input logic        o_index_error
);

    // every accepted item gives its result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted item without result");

    // results never come in consecutive cycles
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results in consecutive cycles");

    // an ignored item returns no mapping
    a_error_no_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_error) |-> !o_mapped_valid)
        else $error("mapping on index error");

    // unmapped results carry a zero index
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_mapped_valid) |-> (o_mapped_index == 12'd0))
        else $error("nonzero index without mapping");

    // reset starts the clear sweep
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

endmodule

bind mesh_point_renumber_table_core mprt_checker u_mprt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_mapped_index (o_mapped_index),
    .o_mapped_valid (o_mapped_valid),
    .o_index_error  (o_index_error)
);
